// ===== rtl/glmf_pkg.sv =====
`default_nettype none

package glmf_pkg;

    // Grid geometry
    localparam int MAX_COLUMNS  = 128;
    localparam int MAX_ROWS     = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int COL_BITS     = $clog2(MAX_COLUMNS);
    localparam int COL_CNT_BITS = COL_BITS + 1;
    localparam int ROW_BITS     = $clog2(MAX_ROWS);
    localparam int ROW_CNT_BITS = ROW_BITS + 1;

    // Four neighbours per cell: up, left, right, below
    localparam int NBR_COUNT = 4;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = ROW_CNT_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_COUNT = 2'd1;

    // Request operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic    operation;
        sample_t sample;
    } glmf_in_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] cell_row;
        logic [COL_BITS-1:0] cell_column;
        logic                is_peak;
        logic                last_cell;
    } glmf_out_t;

    // One word of the line store: the two lines held at one column
    typedef struct packed {
        sample_t upper;
        sample_t middle;
    } line_word_t;

    // Data handed from cell to cell along the compare chain
    typedef struct packed {
        logic                     valid;
        logic [ROW_BITS-1:0]      row;
        logic [COL_BITS-1:0]      column;
        logic                     last;
        logic                     peak;
        sample_t                  center;
        sample_t [NBR_COUNT-1:0]  nbr;
    } cell_t;

endpackage

`default_nettype wire

// ===== rtl/glmf_cell.sv =====
`default_nettype none

module glmf_cell
    import glmf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire cell_t cell_in,
    output cell_t      cell_out
);

    logic  valid_reg;
    cell_t data_reg;
    cell_t data_next;

    // Check one neighbour, then shift the rest down for the next cell
    always_comb
    begin
        data_next      = cell_in;
        data_next.peak = cell_in.peak
                         && ($signed(cell_in.center) >= $signed(cell_in.nbr[0]));
        for (int i = 0; i < NBR_COUNT - 1; i++)
        begin
            data_next.nbr[i] = cell_in.nbr[i+1];
        end
        data_next.nbr[NBR_COUNT-1] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        cell_out       = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/grid_local_maximum_finder_unit.sv =====
// Four-neighbour local maximum finder for a streamed grid.
//
// Requests: in_valid / in_stall carry one glmf_in_t per cycle while in_stall is low, grid samples
// in row-major order, followed after the last row by one flush request per
// column (operation = flush, taken as zero below). A request is taken at a
// rising edge with in_valid high and in_stall low.
// Results: out_valid / out_stall carry one glmf_out_t for every decided cell,
// i.e. for every request outside the first grid row. Row 0 requests give no
// result. A cell is a peak when it is >= its up, left, right and below
// neighbours; neighbours off the grid count as zero.
// Configuration: cfg_valid / cfg_ready (always ready) write row_count
// (index 0) or column_count (index 1); either write restarts the grid at
// row 0, column 0. Write only while no request is in flight.
// Pipeline: a result passes one line store read stage and then a chain of four
// compare cells. Throughput: one request per cycle while in_stall is low,
// bounded by the single write port of the line store.
// When out_stall holds a valid result, the whole chain freezes and in_stall
// rises in the same cycle; no result is dropped. Reset clears the positions,
// sets both sizes to 1 and empties the chain; the line store is not cleared.

`default_nettype none

module grid_local_maximum_finder_unit
    import glmf_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire glmf_in_t                  in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output glmf_out_t                      out_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // Configuration and stream position
    logic [ROW_CNT_BITS-1:0] row_count_reg;
    logic [COL_CNT_BITS-1:0] column_count_reg;
    logic [ROW_CNT_BITS-1:0] row_pos_reg;
    logic [ROW_CNT_BITS-1:0] row_pos_next;
    logic [COL_BITS-1:0]     col_pos_reg;
    logic [COL_BITS-1:0]     col_pos_next;
    logic [ROW_CNT_BITS-1:0] rows_eff;
    logic [COL_CNT_BITS-1:0] cols_eff;
    logic                    cfg_write;
    logic                    cfg_hit;

    // Line store: upper and middle line, one word per column
    line_word_t line_mem [MAX_COLUMNS];

    // Read stage
    logic                s1_item_reg;
    logic                s1_result_reg;
    logic [COL_BITS-1:0] s1_col_reg;
    logic [ROW_BITS-1:0] s1_row_reg;
    logic                s1_last_reg;
    logic                s1_has_right_reg;
    sample_t             s1_left_reg;
    sample_t             s1_below_reg;
    line_word_t          rd_a_reg;
    sample_t             rd_b_reg;
    sample_t             prev_upper_reg;
    line_word_t          wr_word;

    // Per-request decode
    logic                    advance;
    logic                    accept;
    logic                    last_col;
    logic                    row_wrap;
    logic [ROW_CNT_BITS:0]   row_inc;
    logic [COL_BITS-1:0]     col_b;
    logic                    hit_a;
    logic                    hit_b;
    sample_t                 below_val;
    sample_t                 left_src;
    logic [ROW_CNT_BITS-1:0] row_above;

    // Compare chain
    cell_t chain [NBR_COUNT+1];

    // ------------------------------------------------------------------
    // Sizes: saturate into the legal ranges
    // ------------------------------------------------------------------
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_eff = ROW_CNT_BITS'(1);
        end
        else if (row_count_reg > ROW_CNT_BITS'(MAX_ROWS))
        begin
            rows_eff = ROW_CNT_BITS'(MAX_ROWS);
        end
        else
        begin
            rows_eff = row_count_reg;
        end

        if (column_count_reg == '0)
        begin
            cols_eff = COL_CNT_BITS'(1);
        end
        else if (column_count_reg > COL_CNT_BITS'(MAX_COLUMNS))
        begin
            cols_eff = COL_CNT_BITS'(MAX_COLUMNS);
        end
        else
        begin
            cols_eff = column_count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Handshakes: the chain moves unless a finished result is held
    // ------------------------------------------------------------------
    assign advance   = !(chain[NBR_COUNT].valid && out_stall);
    assign in_stall  = !advance;
    assign accept    = in_valid && advance;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        unique case (cfg_index)
            CFG_ROW_COUNT,
            CFG_COLUMN_COUNT: cfg_hit = 1'b1;
            default:          cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_CNT_BITS'(1);
            column_count_reg <= COL_CNT_BITS'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data[COL_CNT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    assign last_col = ({1'b0, col_pos_reg} + COL_CNT_BITS'(1)) == cols_eff;
    assign row_inc  = {1'b0, row_pos_reg} + (ROW_CNT_BITS+1)'(1);
    assign row_wrap = row_inc > {1'b0, rows_eff};

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cfg_write && cfg_hit)
        begin
            // Restart the grid, keep the line store
            row_pos_next = '0;
            col_pos_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_pos_next = '0;
                row_pos_next = row_wrap ? '0 : row_inc[ROW_CNT_BITS-1:0];
            end
            else
            begin
                col_pos_next = col_pos_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Read stage: fetch column c and c+1, forward the pending write
    // ------------------------------------------------------------------
    assign below_val = (in_data.operation == OP_FLUSH) ? '0 : in_data.sample;
    assign col_b     = col_pos_reg + COL_BITS'(1);
    assign hit_a     = s1_item_reg && (s1_col_reg == col_pos_reg);
    assign hit_b     = s1_item_reg && (s1_col_reg == col_b);
    assign row_above = row_pos_reg - ROW_CNT_BITS'(1);

    // The previous request sat at column c-1, so its new upper entry is
    // the left neighbour; take it from the read stage or from the hold.
    assign left_src = s1_item_reg ? wr_word.upper : prev_upper_reg;

    // First-row requests keep the upper line at zero
    always_comb
    begin
        wr_word.upper  = s1_result_reg ? rd_a_reg.middle : '0;
        wr_word.middle = s1_below_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_item_reg   <= 1'b0;
            s1_result_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_item_reg   <= accept;
            s1_result_reg <= accept && (row_pos_reg != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg       <= col_pos_reg;
            s1_row_reg       <= row_above[ROW_BITS-1:0];
            s1_last_reg      <= (row_pos_reg == rows_eff) && last_col;
            s1_has_right_reg <= !last_col;
            s1_left_reg      <= (col_pos_reg != '0) ? left_src : '0;
            s1_below_reg     <= below_val;
        end
        if (s1_item_reg && advance)
        begin
            prev_upper_reg <= wr_word.upper;
        end
    end

    // Line store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (s1_item_reg)
        begin
            line_mem[s1_col_reg] <= wr_word;
        end
        if (accept)
        begin
            rd_a_reg <= hit_a ? wr_word : line_mem[col_pos_reg];
            rd_b_reg <= hit_b ? wr_word.middle : line_mem[col_b].middle;
        end
    end

    // ------------------------------------------------------------------
    // Compare chain: one neighbour per cell, up, left, right, below
    // ------------------------------------------------------------------
    always_comb
    begin
        chain[0].valid  = s1_result_reg;
        chain[0].row    = s1_row_reg;
        chain[0].column = s1_col_reg;
        chain[0].last   = s1_last_reg;
        chain[0].peak   = 1'b1;
        chain[0].center = rd_a_reg.middle;
        chain[0].nbr[0] = rd_a_reg.upper;
        chain[0].nbr[1] = s1_left_reg;
        chain[0].nbr[2] = s1_has_right_reg ? rd_b_reg : '0;
        chain[0].nbr[3] = s1_below_reg;
    end

    for (genvar g = 0; g < NBR_COUNT; g++)
    begin : g_cell
        glmf_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    // The last cell is the output register
    assign out_valid = chain[NBR_COUNT].valid;

    always_comb
    begin
        out_data.cell_row    = chain[NBR_COUNT].row;
        out_data.cell_column = chain[NBR_COUNT].column;
        out_data.is_peak     = chain[NBR_COUNT].peak;
        out_data.last_cell   = chain[NBR_COUNT].last;
    end

endmodule

`default_nettype wire

// ===== rtl/glmf_checker.sv =====
`default_nettype none

module glmf_checker
    import glmf_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire glmf_out_t out_data
);

    // A held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Requests are only pushed back by a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled without a held result");

    // The cycle after the final cell, the next grid is still in its first row
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.last_cell |=> !out_valid)
        else $error("result right after the final cell");

    // Back-to-back results walk along the row
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) ##1 out_valid |->
            (out_data.cell_column == $past(out_data.cell_column) + 7'd1)
            || (out_data.cell_column == 7'd0))
        else $error("column did not advance");

endmodule

bind grid_local_maximum_finder_unit glmf_checker u_glmf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
    import glmf_pkg::*;

    localparam int HALF_PERIOD       = 2;
    localparam int RESET_CYCLES      = 6;
    // Leave margin for the result pipeline and for row 0 requests still in the chain
    localparam int PIPE_SLACK        = 12;
    localparam int IDLE_LIMIT        = 2000;
    localparam int REPORT_LIMIT      = 10;
    localparam int LONG_HOLD_CYCLES  = 120;
    localparam int LONG_HOLD_SPACING = 400;
    localparam int SMALL_PART_ITEMS  = 120;
    localparam int COLUMN_REG_MASK   = 8'hFF;

    // Index past the two registers; a write there changes nothing
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 2'd2;

    localparam sample_t SAMPLE_MAX = 16'sh7fff;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    glmf_in_t                  in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    glmf_out_t                 out_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Shadow of the block: both lines of the line store, positions and effective sizes
    sample_t   upper_line  [MAX_COLUMNS];
    sample_t   middle_line [MAX_COLUMNS];
    int        grid_rows = 1;
    int        grid_cols = 1;
    int        row_pos   = 0;
    int        col_pos   = 0;

    glmf_out_t cells_due [$];       // decided cells still to come out, oldest first
    glmf_in_t  request_queue [$];   // requests waiting for the driver

    int        fault_count    = 0;
    int        requests_taken = 0;

    grid_local_maximum_finder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic glmf_in_t grid_req(input logic op, input sample_t value);
        glmf_in_t req;
        req.operation = op;
        req.sample    = value;
        return req;
    endfunction

    // Lean on small values so that ties between neighbours come up often
    function automatic sample_t random_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3, 4: return sample_t'(int'($urandom_range(0, 6)) - 3);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Advance the shadow by one accepted request and queue the cell it decides.
    // A flush request always counts as zero, wherever it lands in the grid.
    task automatic decide_cell(input glmf_in_t req);
        int        c;
        sample_t   below;
        sample_t   centre;
        sample_t   nbr_up;
        sample_t   nbr_left;
        sample_t   nbr_right;
        glmf_out_t decided;
        if (col_pos >= grid_cols)
            col_pos = 0;
        if (row_pos > grid_rows)
            row_pos = 0;
        c     = col_pos;
        below = (req.operation == OP_FLUSH) ? sample_t'(0) : req.sample;
        if (row_pos == 0)
        begin
            // First row: fill the store, nothing decided yet
            upper_line[c]  = '0;
            middle_line[c] = below;
        end
        else
        begin
            centre    = middle_line[c];
            nbr_up    = upper_line[c];
            // Left entry of the upper line already holds the row being decided
            nbr_left  = (c > 0) ? upper_line[c - 1] : sample_t'(0);
            nbr_right = (c + 1 < grid_cols) ? middle_line[c + 1] : sample_t'(0);
            decided.cell_row    = ROW_BITS'(row_pos - 1);
            decided.cell_column = COL_BITS'(c);
            decided.is_peak     = (centre >= nbr_up) && (centre >= nbr_left) &&
                                  (centre >= nbr_right) && (centre >= below);
            decided.last_cell   = (row_pos == grid_rows) && (c + 1 == grid_cols);
            cells_due.push_back(decided);
            upper_line[c]  = centre;
            middle_line[c] = below;
        end
        col_pos = c + 1;
        if (col_pos >= grid_cols)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos > grid_rows)
                row_pos = 0;
        end
    endtask

    // Driver: send queued requests in bursts, hold the payload while stalled
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decide_cell(in_data);
                requests_taken <= requests_taken + 1;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= request_queue.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        // New burst; about a third of them follow with no gap at all
                        burst_left = $urandom_range(1, 32);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            3:       gap_left = $urandom_range(10, 20);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on a pattern that changes mode every so often. Twice in
    // the run, once a result is waiting, hold off long enough to back the
    // block up into its request side.
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;
    int          holds_done = 0;
    int          beat       = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            beat++;
            if (mode_left <= 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 150);
            end
            else
            begin
                mode_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (holds_done < 2 && out_valid &&
                     requests_taken >= (holds_done + 1) * LONG_HOLD_SPACING)
            begin
                holds_done++;
                hold_left = LONG_HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ((beat % 5) >= 3);
                endcase
            end
        end
    end

    // Monitor: compare each result with the oldest decided cell
    always @(posedge clk)
    begin : check_result
        glmf_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cells_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result: row %0d col %0d peak %0b last %0b",
                             out_data.cell_row, out_data.cell_column,
                             out_data.is_peak, out_data.last_cell);
            end
            else
            begin
                want = cells_due.pop_front();
                if (out_data.cell_row !== want.cell_row ||
                    out_data.cell_column !== want.cell_column ||
                    out_data.is_peak !== want.is_peak ||
                    out_data.last_cell !== want.last_cell)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display({"result mismatch: expected row %0d col %0d peak %0b last %0b,",
                                  " got row %0d col %0d peak %0b last %0b"},
                                 want.cell_row, want.cell_column, want.is_peak,
                                 want.last_cell, out_data.cell_row, out_data.cell_column,
                                 out_data.is_peak, out_data.last_cell);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Wait until every request is taken and every decided cell is out, then
    // let the chain empty of row 0 requests that decide nothing.
    task automatic settle();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || cells_due.size() != 0);
        repeat (PIPE_SLACK) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        int v;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // Mirror the write: mask to the register width, saturate, restart the grid
        v = value & ((1 << CFG_DATA_BITS) - 1);
        if (idx == CFG_ROW_COUNT)
        begin
            grid_rows = (v < 1) ? 1 : (v > MAX_ROWS) ? MAX_ROWS : v;
            row_pos   = 0;
            col_pos   = 0;
        end
        else if (idx == CFG_COLUMN_COUNT)
        begin
            v         = v & COLUMN_REG_MASK;
            grid_cols = (v < 1) ? 1 : (v > MAX_COLUMNS) ? MAX_COLUMNS : v;
            row_pos   = 0;
            col_pos   = 0;
        end
    endtask

    // Queue one grid plus its flush row. Flip the operation of a share of the
    // requests, cut the grid short when asked, and optionally let everything
    // drain halfway through.
    task automatic queue_grid(input int rows, input int cols, input int flip_pct,
                              input int cut, input bit pause_midway);
        int   total;
        int   n;
        int   r;
        int   c;
        logic flush;
        total = (rows + 1) * cols;
        if (cut >= 0 && cut < total)
            total = cut;
        n = 0;
        @(negedge clk);
        for (r = 0; r <= rows && n < total; r++)
        begin
            for (c = 0; c < cols && n < total; c++)
            begin
                flush = (r == rows);
                if ($urandom_range(0, 99) < flip_pct)
                    flush = !flush;
                request_queue.push_back(grid_req(flush ? OP_FLUSH : OP_SAMPLE, random_sample()));
                n++;
                if (pause_midway && n == total / 2)
                    settle();
            end
        end
    endtask

    initial
    begin : stimulus
        int grids;
        int g;
        int flips;
        int cut;
        int cols_value;
        bit first_phase;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // 2 x 3 grid: sample extremes, ties with the cell above and below,
        // a flush inside the grid and a sample inside the flush row
        write_reg(CFG_ROW_COUNT, 2);
        write_reg(CFG_COLUMN_COUNT, 3);
        @(negedge clk);
        request_queue.push_back(grid_req(OP_SAMPLE, SAMPLE_MAX));
        request_queue.push_back(grid_req(OP_SAMPLE, SAMPLE_MIN));
        request_queue.push_back(grid_req(OP_SAMPLE, 16'sd5));
        request_queue.push_back(grid_req(OP_SAMPLE, SAMPLE_MIN));
        request_queue.push_back(grid_req(OP_FLUSH, SAMPLE_MAX));
        request_queue.push_back(grid_req(OP_SAMPLE, 16'sd5));
        request_queue.push_back(grid_req(OP_FLUSH, -16'sd1));
        request_queue.push_back(grid_req(OP_SAMPLE, SAMPLE_MIN));
        request_queue.push_back(grid_req(OP_FLUSH, 16'sh1234));
        settle();

        // Zero in both registers saturates to a 1 x 1 grid; run two of them
        write_reg(CFG_ROW_COUNT, 0);
        write_reg(CFG_COLUMN_COUNT, 0);
        @(negedge clk);
        request_queue.push_back(grid_req(OP_SAMPLE, -16'sd5));
        request_queue.push_back(grid_req(OP_FLUSH, 16'sd0));
        request_queue.push_back(grid_req(OP_SAMPLE, 16'sd7));
        request_queue.push_back(grid_req(OP_SAMPLE, SAMPLE_MIN));
        settle();

        // Column write above bit 7 keeps only the low byte: five columns.
        // Stop inside the flush row, write the spare index, then go on
        // where the grid left off.
        write_reg(CFG_COLUMN_COUNT, 'h105);
        @(negedge clk);
        request_queue.push_back(grid_req(OP_SAMPLE, 16'sd1));
        request_queue.push_back(grid_req(OP_SAMPLE, 16'sd2));
        request_queue.push_back(grid_req(OP_SAMPLE, 16'sd3));
        request_queue.push_back(grid_req(OP_SAMPLE, 16'sd2));
        request_queue.push_back(grid_req(OP_SAMPLE, 16'sd1));
        request_queue.push_back(grid_req(OP_FLUSH, 16'sd0));
        request_queue.push_back(grid_req(OP_FLUSH, SAMPLE_MAX));
        settle();
        write_reg(CFG_SPARE_INDEX, 'h7ff);
        @(negedge clk);
        request_queue.push_back(grid_req(OP_FLUSH, SAMPLE_MIN));
        request_queue.push_back(grid_req(OP_FLUSH, 16'sd0));
        request_queue.push_back(grid_req(OP_FLUSH, -16'sd1));
        settle();

        // Random small grids: mostly well formed, some with flipped
        // operations, some cut short before the next register write
        first_phase = 1'b1;
        while (requests_taken < SMALL_PART_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       cols_value = 256 + $urandom_range(1, 12);
                1:       cols_value = $urandom_range(13, 40);
                default: cols_value = $urandom_range(0, 12);
            endcase
            case ($urandom_range(0, 2))
                0:
                begin
                    write_reg(CFG_ROW_COUNT, $urandom_range(0, 7));
                end
                1:
                begin
                    write_reg(CFG_COLUMN_COUNT, cols_value);
                end
                default:
                begin
                    write_reg(CFG_COLUMN_COUNT, cols_value);
                    write_reg(CFG_ROW_COUNT, $urandom_range(0, 7));
                end
            endcase
            grids = $urandom_range(1, 3);
            case ($urandom_range(0, 9))
                0, 1:    flips = $urandom_range(5, 25);
                2:       flips = 50;
                default: flips = 0;
            endcase
            for (g = 0; g < grids; g++)
            begin
                cut = -1;
                if (g == grids - 1 && $urandom_range(0, 6) == 0)
                    cut = $urandom_range(1, (grid_rows + 1) * grid_cols - 1);
                queue_grid(grid_rows, grid_cols, flips, cut,
                           first_phase || $urandom_range(0, 4) == 0);
                first_phase = 1'b0;
            end
            settle();
        end

        // Widest grid: a column count above the store depth saturates
        write_reg(CFG_ROW_COUNT, 1);
        write_reg(CFG_COLUMN_COUNT, 200);
        queue_grid(grid_rows, grid_cols, 0, -1, 1'b0);
        settle();

        // Tallest grid: all ones in the row register saturates to the maximum
        write_reg(CFG_COLUMN_COUNT, 1);
        write_reg(CFG_ROW_COUNT, 'h7ff);
        queue_grid(grid_rows, grid_cols, 0, -1, 1'b0);
        settle();

        if (fault_count == 0 && cells_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
